>>> sv/itch_message_field_extractor_top_assert.svh
// Assertion macros for the ITCH field extractor checker.
// Depends on nothing; included by the checker file.
`ifndef ITCH_MESSAGE_FIELD_EXTRACTOR_TOP_ASSERT_SVH
`define ITCH_MESSAGE_FIELD_EXTRACTOR_TOP_ASSERT_SVH

// Condition must never hold outside reset.
`define ITCHFX_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("itchfx: forbidden condition");

// Antecedent implies consequent in the same cycle.
`define ITCHFX_IMPLIES(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("itchfx: implication failed");

// Antecedent implies consequent in the next cycle.
`define ITCHFX_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("itchfx: next-cycle implication failed");

`endif

>>> sv/itchfx_pkg.sv
// Package for the ITCH field extractor: codes, constants and the type and
// field description tables. No dependencies.
package itchfx_pkg;

  localparam int unsigned HEADER_BYTES = 11;
  localparam int unsigned TS_FIRST     = 5;

  typedef enum logic [1:0] {
    CLS_ADMIN    = 2'd0,
    CLS_MARKET   = 2'd1,
    CLS_EXTENDED = 2'd2,
    CLS_UNROUTED = 2'd3
  } rec_class_t;

  typedef enum logic [1:0] {
    PH_LEN_HI = 2'd0,
    PH_LEN_LO = 2'd1,
    PH_BODY   = 2'd2
  } frame_phase_t;

  typedef struct packed {
    logic       known;
    rec_class_t cls;
    logic [3:0] count;
    logic [6:0] start;
  } tdesc_t;

  typedef struct packed {
    logic [5:0] id;
    logic [5:0] off;
    logic [3:0] len;
  } fdesc_t;

  function automatic tdesc_t type_lookup(input logic [7:0] letter);
    tdesc_t t;
    t = '{known: 1'b1, cls: CLS_ADMIN, count: 4'd0, start: 7'd0};
    unique case (letter)
      "S": begin t.count = 4'd1;  t.start = 7'd0;  end
      "R": begin t.count = 4'd14; t.start = 7'd1;  end
      "H": begin t.count = 4'd3;  t.start = 7'd15; end
      "Y": begin t.count = 4'd2;  t.start = 7'd18; end
      "L": begin t.count = 4'd5;  t.start = 7'd20; end
      "V": begin t.count = 4'd3;  t.start = 7'd25; end
      "W": begin t.count = 4'd1;  t.start = 7'd28; end
      "K": begin t.count = 4'd4;  t.start = 7'd29; end
      "J": begin t.count = 4'd5;  t.start = 7'd33; end
      "h": begin t.count = 4'd3;  t.start = 7'd38; end
      "N": begin t.count = 4'd2;  t.start = 7'd41; end
      "O": begin t.count = 4'd8;  t.start = 7'd43; end
      "A": begin t.cls = CLS_MARKET; t.count = 4'd5; t.start = 7'd51; end
      "F": begin t.cls = CLS_MARKET; t.count = 4'd6; t.start = 7'd56; end
      "X": begin t.cls = CLS_MARKET; t.count = 4'd2; t.start = 7'd62; end
      "D": begin t.cls = CLS_MARKET; t.count = 4'd1; t.start = 7'd64; end
      "Q": begin t.cls = CLS_EXTENDED; t.count = 4'd5; t.start = 7'd65; end
      "B": begin t.cls = CLS_EXTENDED; t.count = 4'd1; t.start = 7'd70; end
      "I": begin t.cls = CLS_EXTENDED; t.count = 4'd9; t.start = 7'd71; end
      "E": begin t.cls = CLS_EXTENDED; t.count = 4'd3; t.start = 7'd80; end
      "C": begin t.cls = CLS_EXTENDED; t.count = 4'd5; t.start = 7'd83; end
      "U": begin t.cls = CLS_EXTENDED; t.count = 4'd4; t.start = 7'd88; end
      "P": begin t.cls = CLS_EXTENDED; t.count = 4'd6; t.start = 7'd92; end
      default: t.known = 1'b0;
    endcase
    return t;
  endfunction

  function automatic fdesc_t fd(input int unsigned id, input int unsigned off,
                                input int unsigned len);
    fdesc_t f;
    f.id  = 6'(id);
    f.off = 6'(off);
    f.len = 4'(len);
    return f;
  endfunction

  function automatic fdesc_t field_lookup(input logic [6:0] idx);
    fdesc_t f;
    f = fd(0, 0, 1);
    unique case (idx)
      // admin S, R
      7'd0:  f = fd(0, 0, 1);
      7'd1:  f = fd(1, 0, 8);   7'd2:  f = fd(2, 8, 1);   7'd3:  f = fd(3, 9, 1);
      7'd4:  f = fd(4, 10, 4);  7'd5:  f = fd(5, 14, 1);  7'd6:  f = fd(6, 15, 1);
      7'd7:  f = fd(7, 16, 2);  7'd8:  f = fd(8, 18, 1);  7'd9:  f = fd(9, 19, 1);
      7'd10: f = fd(10, 20, 1); 7'd11: f = fd(11, 21, 1); 7'd12: f = fd(12, 22, 1);
      7'd13: f = fd(13, 23, 4); 7'd14: f = fd(14, 27, 1);
      // H, Y, L
      7'd15: f = fd(1, 0, 8);   7'd16: f = fd(15, 8, 1);  7'd17: f = fd(16, 10, 4);
      7'd18: f = fd(1, 0, 8);   7'd19: f = fd(17, 8, 1);
      7'd20: f = fd(18, 0, 4);  7'd21: f = fd(1, 4, 8);   7'd22: f = fd(19, 12, 1);
      7'd23: f = fd(20, 13, 1); 7'd24: f = fd(21, 14, 1);
      // V, W, K
      7'd25: f = fd(22, 0, 8);  7'd26: f = fd(23, 8, 8);  7'd27: f = fd(24, 16, 8);
      7'd28: f = fd(25, 0, 1);
      7'd29: f = fd(1, 0, 8);   7'd30: f = fd(26, 8, 4);  7'd31: f = fd(27, 12, 1);
      7'd32: f = fd(28, 13, 4);
      // J, h, N
      7'd33: f = fd(1, 0, 8);   7'd34: f = fd(29, 8, 4);  7'd35: f = fd(30, 12, 4);
      7'd36: f = fd(31, 16, 4); 7'd37: f = fd(32, 20, 4);
      7'd38: f = fd(1, 0, 8);   7'd39: f = fd(33, 8, 1);  7'd40: f = fd(34, 9, 1);
      7'd41: f = fd(1, 0, 8);   7'd42: f = fd(35, 8, 1);
      // O
      7'd43: f = fd(1, 0, 8);   7'd44: f = fd(36, 8, 1);  7'd45: f = fd(37, 9, 4);
      7'd46: f = fd(38, 13, 4); 7'd47: f = fd(39, 17, 4); 7'd48: f = fd(40, 21, 8);
      7'd49: f = fd(31, 29, 4); 7'd50: f = fd(30, 33, 4);
      // market A, F, X, D
      7'd51: f = fd(41, 0, 8);  7'd52: f = fd(42, 8, 1);  7'd53: f = fd(43, 9, 4);
      7'd54: f = fd(1, 13, 8);  7'd55: f = fd(44, 21, 4);
      7'd56: f = fd(41, 0, 8);  7'd57: f = fd(42, 8, 1);  7'd58: f = fd(43, 9, 4);
      7'd59: f = fd(1, 13, 8);  7'd60: f = fd(44, 21, 4); 7'd61: f = fd(18, 25, 4);
      7'd62: f = fd(41, 0, 8);  7'd63: f = fd(43, 8, 4);
      7'd64: f = fd(41, 0, 8);
      // extended Q, B, I
      7'd65: f = fd(45, 0, 8);  7'd66: f = fd(1, 8, 8);   7'd67: f = fd(44, 16, 4);
      7'd68: f = fd(46, 20, 8); 7'd69: f = fd(47, 28, 1);
      7'd70: f = fd(46, 0, 8);
      7'd71: f = fd(45, 0, 8);  7'd72: f = fd(48, 8, 8);  7'd73: f = fd(49, 16, 1);
      7'd74: f = fd(1, 17, 8);  7'd75: f = fd(50, 25, 4); 7'd76: f = fd(51, 29, 4);
      7'd77: f = fd(52, 33, 4); 7'd78: f = fd(47, 37, 1); 7'd79: f = fd(53, 38, 1);
      // E, C, U, P
      7'd80: f = fd(41, 0, 8);  7'd81: f = fd(43, 8, 4);  7'd82: f = fd(46, 12, 8);
      7'd83: f = fd(41, 0, 8);  7'd84: f = fd(43, 8, 4);  7'd85: f = fd(46, 12, 8);
      7'd86: f = fd(55, 20, 1); 7'd87: f = fd(44, 21, 4);
      7'd88: f = fd(41, 0, 8);  7'd89: f = fd(54, 8, 8);  7'd90: f = fd(43, 16, 4);
      7'd91: f = fd(44, 20, 4);
      7'd92: f = fd(41, 0, 8);  7'd93: f = fd(42, 8, 1);  7'd94: f = fd(43, 9, 4);
      7'd95: f = fd(1, 13, 8);  7'd96: f = fd(44, 21, 4); 7'd97: f = fd(46, 25, 8);
      default: f = fd(0, 0, 1);
    endcase
    return f;
  endfunction

endpackage

>>> sv/itchfx_if.sv
// Channel interfaces of the ITCH field extractor: input byte requests and
// field result requests. No dependencies.
interface itchfx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink (input valid, data_byte, end_of_stream, output ready);
endinterface

interface itchfx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_class;
  logic [7:0]  message_type;
  logic [47:0] timestamp;
  logic [5:0]  field_id;
  logic [63:0] field_value;
  logic        last;
  logic [31:0] message_count;

  modport source (output valid, record_class, message_type, timestamp, field_id,
                  field_value, last, message_count, input ready);
  modport sink (input valid, record_class, message_type, timestamp, field_id,
                field_value, last, message_count, output ready);
endinterface

>>> sv/itch_message_field_extractor_top.sv
// After a message's last byte, its header (type byte, six timestamp bytes) is read
// back byte by byte, store read then capture, and its type looked up; each field is then
// gathered the same way, offered and held until taken. An empty message shows its result
// in the cycle after its length is taken. Input takes one stream byte per cycle between
// messages and stalls from a message's last byte until its last result is taken.
// Reset clears framing, the message count and output valid; the store is not cleared.
module itch_message_field_extractor_top #(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input logic          clk,
  input logic          rst,
  itchfx_in_if.sink    in_ch,
  itchfx_out_if.source out_ch
);
  import itchfx_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_HRD, S_HCAP, S_LOOK, S_FSTART, S_FRD, S_FCAP, S_OUT
  } state_t;

  state_t       state;
  frame_phase_t phase;
  logic [7:0]   length_high_byte;
  logic [15:0]  bytes_remaining;
  logic [15:0]  byte_position;
  logic [31:0]  completed_messages;
  logic [15:0]  msg_len;
  logic [5:0]   ridx;
  logic         rin;
  logic [2:0]   hcnt;
  logic [3:0]   bcnt;
  logic [6:0]   fpos;
  logic [3:0]   fnum;
  logic [3:0]   fcnt;
  logic [7:0]   rdata;
  rec_class_t   rcls;
  logic [7:0]   mtype;
  logic [47:0]  ts;
  logic [5:0]   fid;
  logic [63:0]  fval;
  logic         flast;

  logic [7:0]   message_store [BUFFER_BYTES];

  logic         in_acc;
  logic         wr_en;
  logic [15:0]  len_word;
  logic [15:0]  pos_next;
  logic [15:0]  rem_next;
  logic [7:0]   rbyte;
  logic [31:0]  count_next;
  logic         ridx_ok;
  tdesc_t       tdesc;
  fdesc_t       fdesc;

  // Input handshake and framing arithmetic
  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign len_word    = {length_high_byte, in_ch.data_byte};
  assign pos_next    = (byte_position != 16'hFFFF) ? byte_position + 16'd1 : byte_position;
  assign rem_next    = (bytes_remaining != 16'd0) ? bytes_remaining - 16'd1 : bytes_remaining;
  assign count_next  = (completed_messages != 32'hFFFF_FFFF) ?
                       completed_messages + 32'd1 : completed_messages;
  assign wr_en       = in_acc && !in_ch.end_of_stream && (phase == PH_BODY) &&
                       (byte_position < 16'(BUFFER_BYTES));
  assign rbyte       = rin ? rdata : 8'd0;
  // Only bytes inside both the message and the store read back
  assign ridx_ok     = (16'(ridx) < msg_len) && (16'(ridx) < 16'(BUFFER_BYTES));
  assign tdesc       = type_lookup(mtype);
  assign fdesc       = field_lookup(fpos);

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      message_store[byte_position[AW-1:0]] <= in_ch.data_byte;
    end
    rdata <= message_store[AW'(ridx)];
  end

  // Framing, field sequencing and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      phase              <= PH_LEN_HI;
      length_high_byte   <= 8'd0;
      bytes_remaining    <= 16'd0;
      byte_position      <= 16'd0;
      completed_messages <= 32'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (in_ch.end_of_stream) begin
              phase           <= PH_LEN_HI;
              bytes_remaining <= 16'd0;
              byte_position   <= 16'd0;
            end else begin
              unique case (phase)
                PH_LEN_LO: begin
                  byte_position <= 16'd0;
                  if (len_word == 16'd0) begin
                    phase              <= PH_LEN_HI;
                    bytes_remaining    <= 16'd0;
                    completed_messages <= count_next;
                    rcls  <= CLS_UNROUTED;
                    mtype <= 8'd0;
                    ts    <= 48'd0;
                    fid   <= 6'd0;
                    fval  <= 64'd0;
                    flast <= 1'b1;
                    state <= S_OUT;
                  end else begin
                    bytes_remaining <= len_word;
                    phase           <= PH_BODY;
                  end
                end
                PH_BODY: begin
                  byte_position   <= pos_next;
                  bytes_remaining <= rem_next;
                  if (rem_next == 16'd0) begin
                    phase              <= PH_LEN_HI;
                    completed_messages <= count_next;
                    msg_len <= pos_next;
                    hcnt    <= 3'd0;
                    ridx    <= 6'd0;
                    state   <= S_HRD;
                  end
                end
                PH_LEN_HI: begin
                  length_high_byte <= in_ch.data_byte;
                  phase            <= PH_LEN_LO;
                end
                default: phase <= PH_LEN_HI;
              endcase
            end
          end
        end
        // Header: type byte, then six timestamp bytes
        S_HRD: begin
          rin   <= ridx_ok;
          state <= S_HCAP;
        end
        S_HCAP: begin
          if (hcnt == 3'd0) begin
            mtype <= rbyte;
          end else begin
            ts <= {ts[39:0], rbyte};
          end
          if (hcnt == 3'd6) begin
            state <= S_LOOK;
          end else begin
            hcnt  <= hcnt + 3'd1;
            ridx  <= 6'(TS_FIRST) + 6'(hcnt);
            state <= S_HRD;
          end
        end
        // Classify the type letter
        S_LOOK: begin
          if (tdesc.known) begin
            rcls  <= tdesc.cls;
            fcnt  <= tdesc.count;
            fpos  <= tdesc.start;
            fnum  <= 4'd0;
            state <= S_FSTART;
          end else begin
            rcls  <= CLS_UNROUTED;
            fid   <= 6'd0;
            fval  <= 64'd0;
            flast <= 1'b1;
            state <= S_OUT;
          end
        end
        // Gather one field big-endian
        S_FSTART: begin
          fval  <= 64'd0;
          bcnt  <= 4'd0;
          ridx  <= 6'(HEADER_BYTES) + fdesc.off;
          state <= S_FRD;
        end
        S_FRD: begin
          rin   <= ridx_ok;
          state <= S_FCAP;
        end
        S_FCAP: begin
          fval <= {fval[55:0], rbyte};
          if (bcnt == fdesc.len - 4'd1) begin
            fid   <= fdesc.id;
            flast <= (fnum == fcnt - 4'd1);
            state <= S_OUT;
          end else begin
            bcnt  <= bcnt + 4'd1;
            ridx  <= ridx + 6'd1;
            state <= S_FRD;
          end
        end
        // Hold the result until taken
        S_OUT: begin
          if (out_ch.ready) begin
            if (flast) begin
              state <= S_IDLE;
            end else begin
              fnum  <= fnum + 4'd1;
              fpos  <= fpos + 7'd1;
              state <= S_FSTART;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = (state == S_OUT);
  assign out_ch.record_class  = rcls;
  assign out_ch.message_type  = mtype;
  assign out_ch.timestamp     = ts;
  assign out_ch.field_id      = fid;
  assign out_ch.field_value   = fval;
  assign out_ch.last          = flast;
  assign out_ch.message_count = completed_messages;

endmodule

>>> sv/itchfx_checker.sv
// Port-level checker for the ITCH field extractor, bound to the top level.
// Depends on itch_message_field_extractor_top_assert.svh and itchfx_pkg.
`include "itch_message_field_extractor_top_assert.svh"

module itchfx_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [1:0]  out_record_class,
  input logic [5:0]  out_field_id,
  input logic [63:0] out_field_value,
  input logic [31:0] out_message_count
);
  import itchfx_pkg::*;

  logic unrouted;
  assign unrouted = out_valid && (out_record_class == CLS_UNROUTED);

  // No byte is taken while a result is pending
  `ITCHFX_NEVER(a_no_overlap, in_ready && out_valid)
  // An unrouted result is the only one of its message
  `ITCHFX_IMPLIES(a_unrouted_last, unrouted, out_last)
  `ITCHFX_IMPLIES(a_unrouted_zero, unrouted, out_field_id == 6'd0 && out_field_value == 64'd0)
  // The count stays put while a message's results drain
  `ITCHFX_NEXT(a_count_hold, out_valid && out_ready && !out_last,
               $stable(out_message_count))

endmodule

bind itch_message_field_extractor_top itchfx_checker u_itchfx_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_last         (out_ch.last),
  .out_record_class (out_ch.record_class),
  .out_field_id     (out_ch.field_id),
  .out_field_value  (out_ch.field_value),
  .out_message_count(out_ch.message_count)
);
